// ===== src/gf131_pkg.sv =====
package gf131_pkg;

	localparam int FieldDegree = 131;
	localparam int WideWidth = FieldDegree + 1;

	localparam logic [WideWidth-1:0] FieldPoly =
		(WideWidth'(1) << FieldDegree) | (WideWidth'(1) << 13) | WideWidth'(7);

	localparam logic [1:0] ModeAdd = 2'd0;
	localparam logic [1:0] ModeMul = 2'd1;
	localparam logic [1:0] ModeInv = 2'd2;

	typedef struct packed {
		logic [1:0]  mode;
		logic [63:0] a_word0;
		logic [63:0] a_word1;
		logic [2:0]  a_top;
		logic [63:0] b_word0;
		logic [63:0] b_word1;
		logic [2:0]  b_top;
	} operand_t;

	typedef struct packed {
		logic [63:0] r_word0;
		logic [63:0] r_word1;
		logic [2:0]  r_top;
		logic        zero_inverse;
	} result_t;

	typedef struct packed {
		logic load;
		logic mul_step;
		logic inv_step;
		logic inv_fin;
	} gf131_cmd_t;

	typedef struct packed {
		logic inv_done;
		logic a_zero;
	} gf131_stat_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL,
		ST_INV,
		ST_DONE
	} gf131_state_t;

endpackage

// ===== src/gf2_131_field_alu.sv =====
// GF(2^131) arithmetic unit, reduction polynomial x^131 + x^13 + x^2 + x + 1. A word is taken
// when start is high and busy is low; its result appears for one cycle with done high and
// must be captured then. Add, reserved codes and inversion of zero go from idle straight to
// the done state; multiply makes one bit-serial shift-and-add step per cycle, one per bit of
// the operand, and any other inverse makes one step of the binary Euclid loop per cycle and
// then a final step. Inverting zero returns 1 with zero_inverse.
module gf2_131_field_alu
	import gf131_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  operand_t operand,
	output logic     busy,
	output logic     done,
	output result_t  result
);

	gf131_cmd_t  cmd;
	gf131_stat_t stat;

	gf131_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.mode   (operand.mode),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	gf131_datapath u_dp (
		.clk     (clk),
		.operand (operand),
		.cmd     (cmd),
		.stat    (stat),
		.result  (result)
	);

`ifndef NO_ASSERTIONS
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n) done |-> busy)
		else $error("done without busy");
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted word did not raise busy");
	a_done_once: assert property (@(posedge clk) disable iff (!arst_n) done |=> !done)
		else $error("result strobed twice");
	a_zero_inv: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.zero_inverse) |-> (result.r_word0 == 64'd1 &&
		result.r_word1 == 64'd0 && result.r_top == 3'd0))
		else $error("zero inverse result is not one");
`endif

endmodule

// ===== src/gf131_datapath.sv =====
module gf131_datapath
	import gf131_pkg::*;
(
	input  logic        clk,
	input  operand_t    operand,
	input  gf131_cmd_t  cmd,
	output gf131_stat_t stat,
	output result_t     result
);

	logic [WideWidth-1:0]   u_q, v_q;
	logic [FieldDegree-1:0] g1_q, g2_q;
	logic                   zflag_q;
	logic [FieldDegree-1:0] a_el, b_el, g1_half, g2_half, acc_x;
	logic                   u_one, v_one, a_zero;

	function automatic logic [FieldDegree-1:0] halve(input logic [FieldDegree-1:0] g);
		logic [WideWidth-1:0] t;
		t = g[0] ? ({1'b0, g} ^ FieldPoly) : {1'b0, g};
		return t[WideWidth-1:1];
	endfunction

	assign a_el = {operand.a_top, operand.a_word1, operand.a_word0};
	assign b_el = {operand.b_top, operand.b_word1, operand.b_word0};
	assign a_zero = (a_el == '0);
	assign u_one = (u_q == WideWidth'(1));
	assign v_one = (v_q == WideWidth'(1));
	assign g1_half = halve(g1_q);
	assign g2_half = halve(g2_q);
	assign acc_x = {g1_q[FieldDegree-2:0], 1'b0} ^
		(g1_q[FieldDegree-1] ? FieldPoly[FieldDegree-1:0] : '0);

	assign stat.inv_done = u_one || v_one;
	assign stat.a_zero = a_zero;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			u_q <= {1'b0, a_el};
			zflag_q <= 1'b0;
			g2_q <= '0;
			case (operand.mode)
				ModeAdd: begin
					g1_q <= a_el ^ b_el;
					v_q <= {1'b0, b_el};
				end
				ModeMul: begin
					g1_q <= '0;
					v_q <= {1'b0, b_el};
				end
				ModeInv: begin
					g1_q <= FieldDegree'(1);
					v_q <= FieldPoly;
					zflag_q <= a_zero;
				end
				default: begin
					g1_q <= '0;
					v_q <= {1'b0, b_el};
				end
			endcase
		end else if (cmd.mul_step) begin
			u_q <= {u_q[WideWidth-2:0], 1'b0};
			g1_q <= acc_x ^ (u_q[FieldDegree-1] ? v_q[FieldDegree-1:0] : '0);
		end else if (cmd.inv_fin) begin
			if (!u_one) begin
				g1_q <= g2_q;
			end
		end else if (cmd.inv_step) begin
			if (!u_q[0]) begin
				u_q <= {1'b0, u_q[WideWidth-1:1]};
				g1_q <= g1_half;
			end else if (!v_q[0]) begin
				v_q <= {1'b0, v_q[WideWidth-1:1]};
				g2_q <= g2_half;
			end else if (u_q > v_q) begin
				u_q <= u_q ^ v_q;
				g1_q <= g1_q ^ g2_q;
			end else begin
				v_q <= v_q ^ u_q;
				g2_q <= g2_q ^ g1_q;
			end
		end
	end

	assign result.r_word0 = g1_q[63:0];
	assign result.r_word1 = g1_q[127:64];
	assign result.r_top = g1_q[FieldDegree-1:128];
	assign result.zero_inverse = zflag_q;

endmodule

// ===== src/gf131_ctrl.sv =====
module gf131_ctrl
	import gf131_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [1:0]  mode,
	input  gf131_stat_t stat,
	output gf131_cmd_t  cmd,
	output logic        busy,
	output logic        done
);

	gf131_state_t state_q, state_d;
	logic [7:0]   cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_IDLE) begin
				cnt_q <= 8'(FieldDegree - 1);
			end else if (state_q == ST_MUL) begin
				cnt_q <= cnt_q - 8'd1;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					if (mode == ModeMul) begin
						state_d = ST_MUL;
					end else if (mode == ModeInv && !stat.a_zero) begin
						state_d = ST_INV;
					end else begin
						state_d = ST_DONE;
					end
				end
			end
			ST_MUL: begin
				if (cnt_q == 8'd0) begin
					state_d = ST_DONE;
				end
			end
			ST_INV: begin
				if (stat.inv_done) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		busy = 1'b1;
		done = 1'b0;
		case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				cmd.load = start;
			end
			ST_MUL: cmd.mul_step = 1'b1;
			ST_INV: begin
				cmd.inv_step = !stat.inv_done;
				cmd.inv_fin = stat.inv_done;
			end
			ST_DONE: done = 1'b1;
			default: busy = 1'b1;
		endcase
	end

endmodule

// ===== tb/tb_top.sv =====
module tb_top;
	import gf131_pkg::*;

	localparam logic [1:0] ModeReserved = 2'd3;

	typedef struct packed {
		logic [130:0] val;
		logic         zflag;
	} field_result_t;

	typedef struct {
		logic [1:0]   mode;
		logic [130:0] a;
		logic [130:0] b;
		bit           typed;
		logic [130:0] r;
		logic         z;
	} vector_t;

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     start = 1'b0;
	operand_t operand = '0;
	logic     busy;
	logic     done;
	result_t  result;

	field_result_t pending_results[$];
	int  error_count = 0;
	int  words_sent = 0;
	int  results_seen = 0;
	int  idle_pct = 0;
	vector_t directed[$];

	gf2_131_field_alu u_top (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.operand(operand),
		.busy(busy),
		.done(done),
		.result(result)
	);

	always #6 clk = ~clk;

	function automatic logic [130:0] gf_mul(logic [130:0] a, logic [130:0] b);
		logic [261:0] p;
		p = '0;
		for (int i = 0; i < 131; i++)
			if (a[i])
				p ^= 262'(b) << i;
		for (int i = 260; i >= 131; i--)
			if (p[i]) begin
				p[i] = 1'b0;
				p[i-131] ^= 1'b1;
				p[i-130] ^= 1'b1;
				p[i-129] ^= 1'b1;
				p[i-118] ^= 1'b1;
			end
		return p[130:0];
	endfunction

	function automatic int poly_degree(logic [131:0] w);
		for (int i = 131; i >= 0; i--)
			if (w[i])
				return i;
		return 0;
	endfunction

	function automatic logic [130:0] gf_inv(logic [130:0] a);
		logic [131:0] u, v, g, h, t;
		int j;
		u = {1'b0, a};
		v = FieldPoly;
		g = 132'd1;
		h = '0;
		while (poly_degree(u) > 0) begin
			j = poly_degree(u) - poly_degree(v);
			if (j < 0) begin
				t = u; u = v; v = t;
				t = g; g = h; h = t;
				j = -j;
			end
			u ^= v << j;
			g ^= h << j;
		end
		return g[130:0];
	endfunction

	function automatic field_result_t predict_alu(logic [1:0] mode, logic [130:0] a,
		logic [130:0] b);
		field_result_t r;
		r = '0;
		case (mode)
			ModeAdd: r.val = a ^ b;
			ModeMul: r.val = gf_mul(a, b);
			ModeInv: begin
				r.zflag = (a == '0);
				r.val = gf_inv(a);
			end
			default: r = '0;
		endcase
		return r;
	endfunction

	task automatic send_word(logic [1:0] mode, logic [130:0] a, logic [130:0] b);
		operand_t w;
		w.mode = mode;
		{w.a_top, w.a_word1, w.a_word0} = a;
		{w.b_top, w.b_word1, w.b_word0} = b;
		if ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < idle_pct) @(posedge clk);
		end
		start <= 1'b1;
		operand <= w;
		@(posedge clk);
		while (busy) @(posedge clk);
		pending_results.insert(pending_results.size(), predict_alu(mode, a, b));
		words_sent++;
	endtask

	function automatic logic [130:0] rand_elem();
		logic [130:0] x;
		x = 131'({$urandom, $urandom, $urandom, $urandom, $urandom});
		case ($urandom_range(9))
			0: x = '0;
			1: x = '1;
			2: x = 131'd1 << $urandom_range(130);
			3: x = x >> $urandom_range(130);
			default: ;
		endcase
		return x;
	endfunction

	task automatic add_vec(logic [1:0] m, logic [130:0] a, logic [130:0] b, bit typed,
		logic [130:0] r, logic z);
		vector_t v;
		v.mode = m; v.a = a; v.b = b; v.typed = typed; v.r = r; v.z = z;
		directed.insert(directed.size(), v);
	endtask

	always @(posedge clk) begin
		field_result_t exp;
		if (arst_n && done) begin
			results_seen++;
			if (pending_results.size() == 0) begin
				$error("unexpected result word %h", result);
				error_count++;
			end else begin
				exp = pending_results.pop_front();
				if (result.r_word0 !== exp.val[63:0]) begin
					$error("r_word0 exp %h got %h", exp.val[63:0], result.r_word0);
					error_count++;
				end
				if (result.r_word1 !== exp.val[127:64]) begin
					$error("r_word1 exp %h got %h", exp.val[127:64], result.r_word1);
					error_count++;
				end
				if (result.r_top !== exp.val[130:128]) begin
					$error("r_top exp %h got %h", exp.val[130:128], result.r_top);
					error_count++;
				end
				if (result.zero_inverse !== exp.zflag) begin
					$error("zero_inverse exp %b got %b", exp.zflag, result.zero_inverse);
					error_count++;
				end
			end
		end
	end

	initial begin
		field_result_t chk;
		logic [130:0] ones;
		ones = '1;
		add_vec(ModeAdd, '0, '0, 1, '0, 0);
		add_vec(ModeAdd, ones, ones, 1, '0, 0);
		add_vec(ModeAdd, ones, '0, 1, ones, 0);
		add_vec(ModeMul, '0, ones, 1, '0, 0);
		add_vec(ModeMul, 131'd1, ones, 1, ones, 0);
		add_vec(ModeMul, ones, ones, 0, '0, 0);
		add_vec(ModeMul, 131'd1 << 130, 131'd1 << 130, 0, '0, 0);
		add_vec(ModeMul, 131'd1 << 130, 131'd2, 1, 131'h2007, 0);
		add_vec(ModeInv, '0, ones, 1, 131'd1, 1);
		add_vec(ModeInv, 131'd1, '0, 1, 131'd1, 0);
		add_vec(ModeInv, ones, ones, 0, '0, 0);
		add_vec(ModeInv, 131'd1 << 130, '0, 0, '0, 0);
		add_vec(ModeInv, 131'd2, '0, 0, '0, 0);
		add_vec(ModeReserved, ones, ones, 1, '0, 0);
		add_vec(ModeReserved, '0, '0, 1, '0, 0);
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed[i]) begin
			if (directed[i].typed) begin
				chk = predict_alu(directed[i].mode, directed[i].a, directed[i].b);
				if (chk.val !== directed[i].r || chk.zflag !== directed[i].z) begin
					$error("table row %0d: val exp %h got %h", i, directed[i].r, chk.val);
					error_count++;
				end
			end
			send_word(directed[i].mode, directed[i].a, directed[i].b);
		end
		start <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		for (int ph = 0; ph < 4; ph++) begin
			idle_pct = (ph == 1 || ph == 3) ? 47 : (ph == 2 ? 23 : 0);
			repeat (470) begin
				logic [1:0] m;
				logic [130:0] a, b;
				m = ($urandom_range(19) == 0) ? ModeReserved : 2'($urandom_range(2));
				a = rand_elem();
				b = rand_elem();
				if (m == ModeInv && $urandom_range(1)) b = '0;
				send_word(m, a, b);
			end
			start <= 1'b0;
			while (pending_results.size() != 0) @(posedge clk);
		end
		repeat (600) @(posedge clk);
		$display("Sent %0d words across add, multiply, inverse and reserved modes;",
			words_sent);
		$display("%0d results checked under four sender idle mixes.", results_seen);
		if (error_count == 0 && pending_results.size() == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end

	initial begin
		#80000000;
		$display("tb_top: done, errors");
		$finish;
	end

endmodule

// ===== filelist.f =====
src/gf131_pkg.sv
src/gf131_datapath.sv
src/gf131_ctrl.sv
src/gf2_131_field_alu.sv
tb/tb_top.sv
